@@ rtl/itaf_pkg.sv @@
// shared types, constants and helpers for the integer to ascii formatter
package itaf_pkg;

    localparam int VALUE_W  = 64;
    localparam int BASE_W   = 2;
    localparam int PREC_W   = 7;
    localparam int FLAG_W   = 6;
    localparam int CHAR_W   = 8;
    localparam int CNT_W    = 3;
    localparam int DIGIT_W  = 4;
    localparam int BCD_W    = 80;
    localparam int DABBLE_W = 7;
    localparam int GROUP_CHARS = 4;

    // radix codes
    localparam logic [BASE_W-1:0] BASE_BIN = 2'd0;
    localparam logic [BASE_W-1:0] BASE_OCT = 2'd1;
    localparam logic [BASE_W-1:0] BASE_DEC = 2'd2;
    localparam logic [BASE_W-1:0] BASE_HEX = 2'd3;

    // flag bit positions
    localparam int FLAG_UNSIGNED  = 0;
    localparam int FLAG_PLUS      = 1;
    localparam int FLAG_BLANK     = 2;
    localparam int FLAG_UPPER     = 3;
    localparam int FLAG_ALTERNATE = 4;
    localparam int FLAG_THOUSANDS = 5;

    // ascii codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_B_UP  = 8'h42;
    localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_B_LO  = 8'h62;
    localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_DABBLE = 9'b000000010,
        ST_DIGIT  = 9'b000000100,
        ST_PAD    = 9'b000001000,
        ST_ALT_HI = 9'b000010000,
        ST_ALT_LO = 9'b000100000,
        ST_SIGN   = 9'b001000000,
        ST_FETCH  = 9'b010000000,
        ST_OUT    = 9'b100000000
    } state_t;

    typedef struct packed {
        logic load;
        logic dabble;
        logic pop;
    } dig_ctrl_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               rest_zero;
        logic               dabble_done;
    } dig_stat_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {4'b0000, d};
        if (d < 4'd10)
            return CH_ZERO + d_ext;
        else if (upper)
            return CH_A_UP + d_ext - 8'd10;
        else
            return CH_A_LO + d_ext - 8'd10;
    endfunction

endpackage

@@ rtl/itaf_in_if.sv @@
// input channel carrying one value to format
interface itaf_in_if import itaf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  value_bits;
    logic [BASE_W-1:0]   base_select;
    logic [PREC_W-1:0]   precision;
    logic [FLAG_W-1:0]   format_flags;

    modport source (output valid, output value_bits, output base_select,
                    output precision, output format_flags, input ready);
    modport sink   (input valid, input value_bits, input base_select,
                    input precision, input format_flags, output ready);
endinterface

@@ rtl/itaf_out_if.sv @@
// output channel carrying one group of up to four characters
interface itaf_out_if import itaf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  char0;
    logic [CHAR_W-1:0]  char1;
    logic [CHAR_W-1:0]  char2;
    logic [CHAR_W-1:0]  char3;
    logic [CNT_W-1:0]   valid_count;
    logic               last_group;

    modport source (output valid, output char0, output char1, output char2,
                    output char3, output valid_count, output last_group, input ready);
    modport sink   (input valid, input char0, input char1, input char2,
                    input char3, input valid_count, input last_group, output ready);
endinterface

@@ rtl/integer_to_ascii_formatter_core.sv @@
// top level: printf style integer to ascii conversion, up to four characters per transfer
//
// One value is taken at a time; the input is not ready until the last group of
// the previous text has been transferred. The text is built right to left in
// the text store, one character per cycle, by a single shift unit: decimal
// values first pass through a binary to bcd conversion, other radixes start at
// once. After that the digits with their commas, the padding zeros, the prefix
// characters and the sign are written in that order; the padding step and the
// sign step are passed through even when there is no padding and no sign.
// Read-out then fetches each group from the store, one store read per cycle
// with registered read data, and offers the group until the receiver takes it.
// No clearing pass is needed after reset.
// base_select: 0 binary, 1 octal, 2 decimal, 3 hex. format_flags: bit0
// unsigned, bit1 plus, bit2 blank, bit3 upper case, bit4 alternate form,
// bit5 thousands grouping. Characters of the final group beyond valid_count
// are zero.
module integer_to_ascii_formatter_core import itaf_pkg::*;
#(
    parameter int TEXT_CHARS    = 128,
    parameter int MAX_PRECISION = 100
)
(
    input  logic       clk,
    input  logic       rst_n,
    itaf_in_if.sink    item,
    itaf_out_if.source result
);

    localparam int AW = $clog2(TEXT_CHARS);
    localparam int PW = $clog2(TEXT_CHARS + 1);

    // sequencer and pointers
    state_t             state_reg, state_next;
    logic [PW-1:0]      pos_reg, pos_next;        // leftmost written character
    logic [PREC_W-1:0]  rem_reg, rem_next;        // digits still owed to the precision
    logic [1:0]         mod3_reg, mod3_next;      // digits since the last comma
    logic               comma_reg, comma_next;    // comma due before the next digit
    logic [PW-1:0]      rd_ptr_reg, rd_ptr_next;  // first character of the current group
    logic [CNT_W-1:0]   issue_reg, issue_next;    // store reads issued in this group
    logic               pend_reg, pend_next;      // read data arrives this cycle
    logic [1:0]         slot_reg, slot_next;

    // per item settings
    logic [CHAR_W-1:0]  sign_reg, sign_next;
    logic               has_sign_reg, has_sign_next;
    logic               upper_reg, upper_next;
    logic               alter_reg, alter_next;
    logic               group_reg, group_next;
    logic [BASE_W-1:0]  base_reg, base_next;
    logic               nonzero_reg, nonzero_next;
    logic               lead_zero_reg, lead_zero_next;
    logic [CHAR_W-1:0]  chars_reg [GROUP_CHARS];
    logic [CHAR_W-1:0]  chars_next [GROUP_CHARS];

    // datapath
    dig_ctrl_t          dig_ctrl;
    dig_stat_t          dig_stat;
    logic [VALUE_W-1:0] magnitude;
    logic               negative;
    logic [PREC_W-1:0]  prec_eff;
    logic               we_req;
    logic               we;
    logic [CHAR_W-1:0]  wdata;
    logic [PW-1:0]      pos_dec;
    logic [PW-1:0]      rd_sum;
    logic [CHAR_W-1:0]  rd_data;
    logic [PW-1:0]      grp_len;
    logic [CNT_W-1:0]   grp_cnt;
    logic               grp_last;

    itaf_digit_unit u_digit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (dig_ctrl),
        .load_value (magnitude),
        .base       (item.base_select),
        .stat       (dig_stat)
    );

    itaf_text_buf #(.TEXT_CHARS(TEXT_CHARS)) u_text
    (
        .clk     (clk),
        .we      (we),
        .waddr   (pos_dec[AW-1:0]),
        .wdata   (wdata),
        .raddr   (rd_sum[AW-1:0]),
        .rd_data (rd_data)
    );

    // sign and magnitude of the incoming value
    assign negative  = !item.format_flags[FLAG_UNSIGNED] && item.value_bits[VALUE_W-1];
    assign magnitude = negative ? (~item.value_bits + 1'b1) : item.value_bits;
    assign prec_eff  = (item.precision > PREC_W'(MAX_PRECISION)) ?
                       PREC_W'(MAX_PRECISION) : item.precision;

    assign pos_dec  = pos_reg - 1'b1;
    assign we       = we_req && (pos_reg != '0);
    assign rd_sum   = rd_ptr_reg + PW'(issue_reg);

    // size of the group starting at the read pointer
    assign grp_len  = PW'(TEXT_CHARS) - rd_ptr_reg;
    assign grp_cnt  = (grp_len >= PW'(GROUP_CHARS)) ? CNT_W'(GROUP_CHARS) : grp_len[CNT_W-1:0];
    assign grp_last = (grp_len <= PW'(GROUP_CHARS));

    assign item.ready         = (state_reg == ST_IDLE);
    assign result.valid       = (state_reg == ST_OUT);
    assign result.char0       = chars_reg[0];
    assign result.char1       = chars_reg[1];
    assign result.char2       = chars_reg[2];
    assign result.char3       = chars_reg[3];
    assign result.valid_count = grp_cnt;
    assign result.last_group  = grp_last;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        rem_next       = rem_reg;
        mod3_next      = mod3_reg;
        comma_next     = comma_reg;
        rd_ptr_next    = rd_ptr_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        slot_next      = slot_reg;
        sign_next      = sign_reg;
        has_sign_next  = has_sign_reg;
        upper_next     = upper_reg;
        alter_next     = alter_reg;
        group_next     = group_reg;
        base_next      = base_reg;
        nonzero_next   = nonzero_reg;
        lead_zero_next = lead_zero_reg;
        for (int i = 0; i < GROUP_CHARS; i++)
            chars_next[i] = chars_reg[i];
        dig_ctrl = '0;
        we_req   = 1'b0;
        wdata    = CH_NUL;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    dig_ctrl.load = 1'b1;
                    pos_next      = PW'(TEXT_CHARS);
                    rem_next      = prec_eff;
                    mod3_next     = '0;
                    comma_next    = 1'b0;
                    upper_next    = item.format_flags[FLAG_UPPER];
                    alter_next    = item.format_flags[FLAG_ALTERNATE];
                    group_next    = item.format_flags[FLAG_THOUSANDS];
                    base_next     = item.base_select;
                    nonzero_next  = (item.value_bits != '0);
                    // minus wins, then plus, then blank; none when unsigned
                    has_sign_next = 1'b1;
                    if (negative)
                        sign_next = CH_MINUS;
                    else if (item.format_flags[FLAG_UNSIGNED])
                    begin
                        sign_next     = CH_NUL;
                        has_sign_next = 1'b0;
                    end
                    else if (item.format_flags[FLAG_PLUS])
                        sign_next = CH_PLUS;
                    else if (item.format_flags[FLAG_BLANK])
                        sign_next = CH_BLANK;
                    else
                    begin
                        sign_next     = CH_NUL;
                        has_sign_next = 1'b0;
                    end
                    state_next = (item.base_select == BASE_DEC) ? ST_DABBLE : ST_DIGIT;
                end
            end

            ST_DABBLE:
            begin
                if (dig_stat.dabble_done)
                    state_next = ST_DIGIT;
                else
                    dig_ctrl.dabble = 1'b1;
            end

            ST_DIGIT:
            begin
                we_req = 1'b1;
                if (comma_reg)
                begin
                    wdata      = CH_COMMA;
                    comma_next = 1'b0;
                end
                else
                begin
                    wdata        = digit_char(dig_stat.digit, upper_reg);
                    dig_ctrl.pop = 1'b1;
                    if (rem_reg != '0)
                        rem_next = rem_reg - 1'b1;
                    mod3_next = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 1'b1;
                    // comma only between converted digits
                    if (dig_stat.rest_zero)
                        state_next = ST_PAD;
                    else if (group_reg && (mod3_reg == 2'd2))
                        comma_next = 1'b1;
                end
            end

            ST_PAD:
            begin
                if (rem_reg != '0)
                begin
                    we_req   = 1'b1;
                    wdata    = CH_ZERO;
                    rem_next = rem_reg - 1'b1;
                end
                else if (alter_reg && (base_reg == BASE_OCT) && !lead_zero_reg)
                    state_next = ST_ALT_LO;
                else if (alter_reg && nonzero_reg &&
                         ((base_reg == BASE_HEX) || (base_reg == BASE_BIN)))
                    state_next = ST_ALT_HI;
                else
                    state_next = ST_SIGN;
            end

            ST_ALT_HI:
            begin
                we_req = 1'b1;
                if (base_reg == BASE_HEX)
                    wdata = upper_reg ? CH_X_UP : CH_X_LO;
                else
                    wdata = upper_reg ? CH_B_UP : CH_B_LO;
                state_next = ST_ALT_LO;
            end

            ST_ALT_LO:
            begin
                we_req     = 1'b1;
                wdata      = CH_ZERO;
                state_next = ST_SIGN;
            end

            ST_SIGN:
            begin
                we_req      = has_sign_reg;
                wdata       = sign_reg;
                rd_ptr_next = (has_sign_reg && (pos_reg != '0)) ? pos_dec : pos_reg;
                issue_next  = '0;
                pend_next   = 1'b0;
                for (int i = 0; i < GROUP_CHARS; i++)
                    chars_next[i] = CH_NUL;
                state_next  = ST_FETCH;
            end

            ST_FETCH:
            begin
                // one store read per cycle, data lands in the next cycle
                if (issue_reg < grp_cnt)
                begin
                    pend_next  = 1'b1;
                    slot_next  = issue_reg[1:0];
                    issue_next = issue_reg + 1'b1;
                end
                else
                    pend_next = 1'b0;
                if (pend_reg)
                begin
                    chars_next[slot_reg] = rd_data;
                    if ({1'b0, slot_reg} == grp_cnt - 1'b1)
                        state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (result.ready)
                begin
                    rd_ptr_next = rd_ptr_reg + PW'(grp_cnt);
                    issue_next  = '0;
                    pend_next   = 1'b0;
                    for (int i = 0; i < GROUP_CHARS; i++)
                        chars_next[i] = CH_NUL;
                    state_next  = grp_last ? ST_IDLE : ST_FETCH;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (we)
        begin
            pos_next       = pos_dec;
            lead_zero_next = (wdata == CH_ZERO);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pos_reg    <= PW'(TEXT_CHARS);
            rem_reg    <= '0;
            mod3_reg   <= '0;
            comma_reg  <= 1'b0;
            rd_ptr_reg <= PW'(TEXT_CHARS);
            issue_reg  <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            rem_reg    <= rem_next;
            mod3_reg   <= mod3_next;
            comma_reg  <= comma_next;
            rd_ptr_reg <= rd_ptr_next;
            issue_reg  <= issue_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        sign_reg      <= sign_next;
        has_sign_reg  <= has_sign_next;
        upper_reg     <= upper_next;
        alter_reg     <= alter_next;
        group_reg     <= group_next;
        base_reg      <= base_next;
        nonzero_reg   <= nonzero_next;
        lead_zero_reg <= lead_zero_next;
        for (int i = 0; i < GROUP_CHARS; i++)
            chars_reg[i] <= chars_next[i];
    end

`ifndef SYNTHESIS
    // input and output sides never open together
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(item.ready && result.valid))
        else $error("input ready while a group is offered");

    // the text never runs past the left end of the store
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        we_req |-> (pos_reg != '0))
        else $error("text store overflow");

    // every offered group holds one to four characters
    a_group_size: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ((result.valid_count != '0) && (result.valid_count <= 3'd4)))
        else $error("bad group size");

    // after the final group the block takes a new item at once
    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && result.last_group) |=> item.ready)
        else $error("not idle after final group");
`endif

endmodule

@@ rtl/itaf_digit_unit.sv @@
// shared shift unit: binary to bcd conversion and least significant digit extraction
module itaf_digit_unit import itaf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dig_ctrl_t          ctrl,
    input  logic [VALUE_W-1:0] load_value,
    input  logic [BASE_W-1:0]  base,
    output dig_stat_t          stat
);

    logic [BCD_W-1:0]    acc_reg;
    logic [VALUE_W-1:0]  bin_reg;
    logic [BASE_W-1:0]   base_reg;
    logic [DABBLE_W-1:0] count_reg;
    logic [BCD_W-1:0]    corrected;
    logic [BCD_W-1:0]    shifted;
    logic [DIGIT_W-1:0]  digit;

    // add-3 correction on every bcd digit
    always_comb
    begin
        for (int i = 0; i < BCD_W / DIGIT_W; i++)
        begin
            if (acc_reg[i*DIGIT_W +: DIGIT_W] >= 4'd5)
                corrected[i*DIGIT_W +: DIGIT_W] = acc_reg[i*DIGIT_W +: DIGIT_W] + 4'd3;
            else
                corrected[i*DIGIT_W +: DIGIT_W] = acc_reg[i*DIGIT_W +: DIGIT_W];
        end
    end

    always_comb
    begin
        case (base_reg)
            BASE_BIN:
            begin
                shifted = acc_reg >> 1;
                digit   = {3'b000, acc_reg[0]};
            end
            BASE_OCT:
            begin
                shifted = acc_reg >> 3;
                digit   = {1'b0, acc_reg[2:0]};
            end
            default:
            begin
                shifted = acc_reg >> 4;
                digit   = acc_reg[3:0];
            end
        endcase
    end

    assign stat.digit       = digit;
    assign stat.rest_zero   = (shifted == '0);
    assign stat.dabble_done = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctrl.load)
        begin
            count_reg <= (base == BASE_DEC) ? DABBLE_W'(VALUE_W) : '0;
        end
        else if (ctrl.dabble)
        begin
            count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            base_reg <= base;
            if (base == BASE_DEC)
            begin
                acc_reg <= '0;
                bin_reg <= load_value;
            end
            else
            begin
                acc_reg <= {{(BCD_W-VALUE_W){1'b0}}, load_value};
                bin_reg <= load_value;
            end
        end
        else if (ctrl.dabble)
        begin
            acc_reg <= {corrected[BCD_W-2:0], bin_reg[VALUE_W-1]};
            bin_reg <= {bin_reg[VALUE_W-2:0], 1'b0};
        end
        else if (ctrl.pop)
        begin
            acc_reg <= shifted;
        end
    end

endmodule

@@ rtl/itaf_text_buf.sv @@
// text store: one write port, one registered read port
module itaf_text_buf import itaf_pkg::*;
#(
    parameter int TEXT_CHARS = 128
)
(
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(TEXT_CHARS)-1:0] waddr,
    input  logic [CHAR_W-1:0]             wdata,
    input  logic [$clog2(TEXT_CHARS)-1:0] raddr,
    output logic [CHAR_W-1:0]             rd_data
);

    logic [CHAR_W-1:0] mem [TEXT_CHARS];
    logic [CHAR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_data_reg <= mem[raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the integer to ascii formatter core
`timescale 1ns / 1ps

module testbench import itaf_pkg::*;
;

    // run shape
    localparam int CLK_HALF_NS  = 5;
    localparam int RESET_CYCLES = 9;
    localparam int HOLD_CYCLES  = 400;   // longer than the slowest text, so the input backs up
    localparam int DRAIN_CYCLES = 320;   // about one maximum precision binary text
    localparam int PHASE_ITEMS  = 40;
    localparam int TIMEOUT_NS   = 30_000_000;

    // flag masks built from the package bit positions
    localparam logic [FLAG_W-1:0] F_UNS   = FLAG_W'(1 << FLAG_UNSIGNED);
    localparam logic [FLAG_W-1:0] F_PLUS  = FLAG_W'(1 << FLAG_PLUS);
    localparam logic [FLAG_W-1:0] F_BLANK = FLAG_W'(1 << FLAG_BLANK);
    localparam logic [FLAG_W-1:0] F_UPPER = FLAG_W'(1 << FLAG_UPPER);
    localparam logic [FLAG_W-1:0] F_ALT   = FLAG_W'(1 << FLAG_ALTERNATE);
    localparam logic [FLAG_W-1:0] F_THOU  = FLAG_W'(1 << FLAG_THOUSANDS);
    localparam logic [FLAG_W-1:0] F_NONE  = '0;

    localparam int TEXT_LIMIT    = 128;
    localparam int PREC_SATURATE = 100;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value_bits;
        logic [BASE_W-1:0]  base_select;
        logic [PREC_W-1:0]  precision;
        logic [FLAG_W-1:0]  format_flags;
    } fmt_req_t;

    typedef struct packed {
        logic [GROUP_CHARS-1:0][CHAR_W-1:0] chars;
        logic [CNT_W-1:0]                   valid_count;
        logic                               last_group;
    } char_group_t;

    logic clk;
    logic rst_n;

    itaf_in_if  item_ch ();
    itaf_out_if result_ch ();

    integer_to_ascii_formatter_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch.sink),
        .result (result_ch.source)
    );

    // values waiting to be offered, and the character groups they must produce
    fmt_req_t    pending_items[$];
    char_group_t expected_groups[$];
    fmt_req_t    offered;

    int issued_items   = 0;
    int accepted_items = 0;
    int groups_checked = 0;
    int errors         = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;

    // receiver hold-off, armed once by the sequence and counted down on its own
    logic hold_armed;
    logic hold_done;
    int   hold_cnt;

    // -------------------------------------------------------------------------
    // clock and the single reset at the start of the run
    // -------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF_NS clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    // -------------------------------------------------------------------------
    // text predictor: builds the printed number right to left, then cuts it
    // into groups of four characters, in the order the block transfers them
    // -------------------------------------------------------------------------
    function automatic void predict_text(input fmt_req_t req);
        logic [CHAR_W-1:0]  txt[$];
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] radix;
        logic [CHAR_W-1:0]  sign_ch;
        logic               is_uns;
        logic               upper;
        logic               alt;
        logic               grouped;
        string              digit_set;
        char_group_t        grp_out;
        int                 owed;
        int                 ndig;
        int                 len;
        int                 cnt;
        int                 g;
        int                 k;

        is_uns  = req.format_flags[FLAG_UNSIGNED];
        upper   = req.format_flags[FLAG_UPPER];
        alt     = req.format_flags[FLAG_ALTERNATE];
        grouped = req.format_flags[FLAG_THOUSANDS];
        digit_set = upper ? "0123456789ABCDEF" : "0123456789abcdef";

        case (req.base_select)
            BASE_BIN: radix = 64'd2;
            BASE_OCT: radix = 64'd8;
            BASE_DEC: radix = 64'd10;
            default:  radix = 64'd16;
        endcase

        // precision above the ceiling saturates; zero acts like one
        owed = (int'(req.precision) > PREC_SATURATE) ? PREC_SATURATE : int'(req.precision);

        // sign choice: minus for negative signed values, plus beats blank
        mag     = req.value_bits;
        sign_ch = CH_NUL;
        if (!is_uns)
        begin
            if (req.value_bits[VALUE_W-1])
            begin
                sign_ch = CH_MINUS;
                mag     = ~req.value_bits + 64'd1;
            end
            else if (req.format_flags[FLAG_PLUS])
                sign_ch = CH_PLUS;
            else if (req.format_flags[FLAG_BLANK])
                sign_ch = CH_BLANK;
        end

        // at least one digit, commas only between converted digits
        ndig = 0;
        do
        begin
            txt.push_front(digit_set[int'(mag % radix)]);
            mag = mag / radix;
            ndig++;
            if (grouped && (ndig % 3) == 0 && mag != 0)
                txt.push_front(CH_COMMA);
            owed--;
        end
        while (mag != 0);

        // padding zeros never carry commas
        while (owed > 0)
        begin
            txt.push_front(CH_ZERO);
            owed--;
        end

        // alternate form: octal gets a zero unless one leads already,
        // hex and binary get their prefix only for a nonzero value
        if (alt)
        begin
            if (req.base_select == BASE_OCT)
            begin
                if (txt[0] != CH_ZERO)
                    txt.push_front(CH_ZERO);
            end
            else if (req.base_select == BASE_HEX && req.value_bits != '0)
            begin
                txt.push_front(upper ? CH_X_UP : CH_X_LO);
                txt.push_front(CH_ZERO);
            end
            else if (req.base_select == BASE_BIN && req.value_bits != '0)
            begin
                txt.push_front(upper ? CH_B_UP : CH_B_LO);
                txt.push_front(CH_ZERO);
            end
        end

        if (sign_ch != CH_NUL)
            txt.push_front(sign_ch);

        // the longest text fits the store, so nothing is dropped at the left
        len = (txt.size() > TEXT_LIMIT) ? TEXT_LIMIT : txt.size();

        // unused slots of the final group stay zero
        for (g = 0; g * GROUP_CHARS < len; g++)
        begin
            cnt = len - g * GROUP_CHARS;
            if (cnt > GROUP_CHARS)
                cnt = GROUP_CHARS;
            grp_out = '0;
            for (k = 0; k < cnt; k++)
                grp_out.chars[k] = txt[g * GROUP_CHARS + k];
            grp_out.valid_count = CNT_W'(cnt);
            grp_out.last_group  = (g * GROUP_CHARS + cnt == len);
            expected_groups.push_back(grp_out);
        end
    endfunction

    // -------------------------------------------------------------------------
    // sender: offers pending values, holds each until its transfer, and
    // predicts the text of every value the block takes
    // -------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid        <= 1'b0;
            item_ch.value_bits   <= '0;
            item_ch.base_select  <= BASE_BIN;
            item_ch.precision    <= '0;
            item_ch.format_flags <= F_NONE;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                predict_text(offered);
                accepted_items++;
            end
            // a new offer only once the current one has been taken
            if (!item_ch.valid || item_ch.ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered = pending_items.pop_front();
                    item_ch.valid        <= 1'b1;
                    item_ch.value_bits   <= offered.value_bits;
                    item_ch.base_select  <= offered.base_select;
                    item_ch.precision    <= offered.precision;
                    item_ch.format_flags <= offered.format_flags;
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // -------------------------------------------------------------------------
    // long receiver hold-off: loaded once when armed, then counts down
    // -------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_armed && !hold_done)
        begin
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
    end

    // -------------------------------------------------------------------------
    // receiver: random stalls, and every transfer checked against the oldest
    // expected group, field by field
    // -------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : receiver
        char_group_t got;
        char_group_t want;
        int          k;

        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got.chars       = {result_ch.char3, result_ch.char2,
                                   result_ch.char1, result_ch.char0};
                got.valid_count = result_ch.valid_count;
                got.last_group  = result_ch.last_group;
                if (expected_groups.size() == 0)
                begin
                    $display("%0t: group with nothing expected: chars %h count %0d last %0d",
                             $time, got.chars, got.valid_count, got.last_group);
                    errors++;
                end
                else
                begin
                    want = expected_groups.pop_front();
                    groups_checked++;
                    for (k = 0; k < GROUP_CHARS; k++)
                    begin
                        if (got.chars[k] !== want.chars[k])
                        begin
                            $display("%0t: char%0d expected %h actual %h",
                                     $time, k, want.chars[k], got.chars[k]);
                            errors++;
                        end
                    end
                    if (got.valid_count !== want.valid_count)
                    begin
                        $display("%0t: valid_count expected %0d actual %0d",
                                 $time, want.valid_count, got.valid_count);
                        errors++;
                    end
                    if (got.last_group !== want.last_group)
                    begin
                        $display("%0t: last_group expected %0d actual %0d",
                                 $time, want.last_group, got.last_group);
                        errors++;
                    end
                end
            end
            result_ch.ready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // -------------------------------------------------------------------------
    // stimulus helpers
    // -------------------------------------------------------------------------
    function automatic void queue_item(input logic [VALUE_W-1:0] v,
                                       input logic [BASE_W-1:0]  b,
                                       input int                 p,
                                       input logic [FLAG_W-1:0]  f);
        fmt_req_t req;
        req.value_bits   = v;
        req.base_select  = b;
        req.precision    = PREC_W'(p);
        req.format_flags = f;
        pending_items.push_back(req);
        issued_items++;
    endfunction

    // mostly short magnitudes and small precisions, now and then the extremes
    task automatic queue_random(input int n);
        logic [VALUE_W-1:0] v;
        int                 i;
        int                 r;
        int                 p;
        for (i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            v = {$urandom, $urandom};
            if (r < 10)
            begin
                case ($urandom_range(4))
                    0: v = '0;
                    1: v = 64'd1;
                    2: v = '1;
                    3: v = 64'h8000_0000_0000_0000;
                    default: v = 64'h7FFF_FFFF_FFFF_FFFF;
                endcase
            end
            else if (r < 60)
                v = v >> $urandom_range(63);
            else if (r < 75)
                v = ~(v >> $urandom_range(63)) + 64'd1;
            r = $urandom_range(99);
            if (r < 80)
                p = $urandom_range(12);
            else if (r < 92)
                p = $urandom_range(100, 13);
            else
                p = $urandom_range(127, 101);
            queue_item(v, BASE_W'($urandom_range(3)), p, FLAG_W'($urandom_range(63)));
        end
    endtask

    // waits until every value has been taken and every group has arrived, then waits out the drain time
    task automatic wait_drained();
        while (accepted_items != issued_items || expected_groups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_idling(input idle_mode_t mode);
        send_idle_pct = (mode == IDLE_SEND) ? 62 : (mode == IDLE_BOTH) ? 23 : 0;
        recv_idle_pct = (mode == IDLE_RECV) ? 62 : (mode == IDLE_BOTH) ? 23 : 0;
    endtask

    // -------------------------------------------------------------------------
    // sequence: directed corners, random phases under each idling pattern,
    // then a phase with a long receiver hold-off
    // -------------------------------------------------------------------------
    initial
    begin : sequence_main
        idle_mode_t mode;

        hold_armed = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        set_idling(IDLE_NONE);
        // zero prints one digit; no prefix on zero for hex or binary
        queue_item('0, BASE_DEC, 0, F_NONE);
        queue_item('0, BASE_HEX, 0, F_ALT);
        queue_item('0, BASE_OCT, 0, F_ALT);
        queue_item('0, BASE_BIN, 1, F_ALT | F_UPPER | F_PLUS);
        // most negative value and unsigned all ones, grouped, then signed all ones
        queue_item(64'h8000_0000_0000_0000, BASE_DEC, 0, F_THOU);
        queue_item('1, BASE_DEC, 0, F_UNS | F_THOU);
        queue_item('1, BASE_DEC, 0, F_NONE);
        // sign choice
        queue_item(64'd5, BASE_DEC, 0, F_PLUS);
        queue_item(64'd5, BASE_DEC, 0, F_BLANK);
        queue_item(64'd5, BASE_DEC, 0, F_PLUS | F_BLANK);
        queue_item(64'd5, BASE_DEC, 0, F_UNS | F_PLUS | F_BLANK);
        // long text: saturated precision, grouped binary with prefix
        queue_item('1, BASE_BIN, 127, F_UNS | F_THOU | F_ALT | F_UPPER);
        // hex prefix in both cases
        queue_item(64'hDEAD_BEEF, BASE_HEX, 0, F_ALT);
        queue_item(64'hCAFE, BASE_HEX, 0, F_ALT | F_UPPER);
        // octal prefix only when no zero leads
        queue_item(64'd8, BASE_OCT, 0, F_ALT);
        queue_item(64'd8, BASE_OCT, 5, F_ALT);
        // grouping, and padding zeros without commas
        queue_item(64'd1234567, BASE_DEC, 0, F_THOU);
        queue_item(64'd123, BASE_DEC, 6, F_THOU);
        queue_item(64'd1000, BASE_DEC, 2, F_THOU | F_ALT);
        queue_item(64'd42, BASE_DEC, 0, F_ALT);
        // negative hex keeps the sign ahead of the prefix
        queue_item(64'hFFFF_FFFF_FFFF_FFF0, BASE_HEX, 0, F_ALT | F_BLANK);
        queue_item(64'd7, BASE_DEC, 100, F_NONE);
        queue_item('0, BASE_DEC, 1, F_PLUS);
        queue_item(64'd1, BASE_BIN, 0, F_ALT);
        queue_item('1, BASE_OCT, 0, F_UNS | F_ALT | F_THOU);
        wait_drained();

        // random content under each idling pattern
        for (mode = IDLE_NONE; mode <= IDLE_BOTH; mode = idle_mode_t'(int'(mode) + 1))
        begin
            set_idling(mode);
            queue_random(PHASE_ITEMS);
            wait_drained();
            if (mode == IDLE_BOTH)
                break;
        end

        // receiver held off while the sender keeps offering
        set_idling(IDLE_NONE);
        queue_random(PHASE_ITEMS);
        @(posedge clk);
        hold_armed <= 1'b1;
        wait_drained();

        if (expected_groups.size() != 0)
        begin
            $display("%0t: %0d expected groups never arrived", $time, expected_groups.size());
            errors++;
        end

        $display("covered %0d values and %0d character groups over four idling patterns",
                 accepted_items, groups_checked);
        $display("plus a %0d-cycle receiver hold-off with the input backed up", HOLD_CYCLES);
        if (errors == 0)
            $display("integer_to_ascii_formatter_core regression: pass");
        else
            $display("integer_to_ascii_formatter_core regression: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #TIMEOUT_NS;
        $display("%0t: timeout with %0d groups outstanding", $time, expected_groups.size());
        $display("integer_to_ascii_formatter_core regression: fail");
        $finish;
    end

endmodule
